/* src/auto_brightness_hysteresis_top_macros.svh */
// Assertion macros used by the checker file of the auto brightness block.
// No dependencies; include by bare file name.
`ifndef AUTO_BRIGHTNESS_HYSTERESIS_TOP_MACROS_SVH
`define AUTO_BRIGHTNESS_HYSTERESIS_TOP_MACROS_SVH

// Check a property outside reset.
`define ABH_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property at every edge, reset included.
`define ABH_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* src/abh_pkg.sv */
// Shared constants, register codes and controller/datapath interface types
// for the auto brightness block. No dependencies.
package abh_pkg;

    localparam int SAMPLE_BITS = 10;
    localparam int S_TDATA_W   = ((SAMPLE_BITS + 7) / 8) * 8;
    localparam int M_TDATA_W   = 8;

    localparam int GAIN_W      = 9;
    localparam int MODE_W      = 2;
    localparam int LEVEL_W     = 8;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 9;
    localparam int LAST_W      = 13;

    // Gain product, and the quotient by 100 (at least six bits narrower).
    localparam int PROD_W      = SAMPLE_BITS + GAIN_W;
    localparam int SCALED_W    = PROD_W - 6;
    localparam int LPROD_W     = SCALED_W + LEVEL_W;
    localparam int SUM_W       = SCALED_W + 1;

    // floor(x / 100) == (x * RECIP_100) >> RECIP_SHIFT for x < 2**RECIP_SHIFT / 44
    localparam int RECIP_W     = 22;
    localparam int RECIP_SHIFT = 28;
    localparam logic [RECIP_W-1:0] RECIP_100 = 22'd2684355;

    localparam logic [CFG_IDX_W-1:0] CFG_GAIN     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MODE     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LEVEL    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_BOOST    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_ALERT_EN = 3'd4;

    localparam logic [MODE_W-1:0] MODE_AUTO   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_SCALED = 2'd1;

    localparam logic [GAIN_W-1:0]  GAIN_RST        = 9'd100;
    localparam logic [MODE_W-1:0]  MODE_RST        = MODE_AUTO;
    localparam logic [LEVEL_W-1:0] LEVEL_RST       = 8'd128;
    localparam logic [LEVEL_W-1:0] BOOST_RST       = 8'd0;
    localparam logic [LAST_W-1:0]  LAST_SAMPLE_RST = 13'd5000;

    localparam logic [SUM_W-1:0]   BRIGHT_MAX = SUM_W'(255);

    typedef struct packed {
        logic load_in;
        logic calc_div;
        logic calc_map;
        logic commit;
    } abh_cmd_t;

    typedef struct packed {
        logic update;
        logic out_free;
    } abh_stat_t;

endpackage

/* src/auto_brightness_hysteresis_top.sv */
// Top level of the auto brightness block with deadband hysteresis.
// Depends on abh_pkg, abh_ctrl and abh_datapath.
//
//  channel   direction  handshake            payload
//  s_*       in         s_tvalid/s_tready    tdata: light_sample; tuser: boost_active
//  m_*       out        m_tvalid/m_tready    tdata: brightness; tuser: light_alert
//  cfg_*     in         cfg_we (no wait)     cfg_index, cfg_data
//
// A request that changes the brightness passes these steps from accept to a loaded
// output register: compare and gain multiply, divide by reciprocal multiply,
// level multiply, map and clamp.
// A request inside the deadband is dropped at the divide step.
// The final step holds while the output register is full and not taken.
// Reset clears the stored sample to 5000 and the boost flag to 1.
module auto_brightness_hysteresis_top
    import abh_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [S_TDATA_W-1:0]  s_tdata,   // [9:0] light_sample, rest zero
    input  logic                  s_tuser,   // [0] boost_active
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_TDATA_W-1:0]  m_tdata,   // [7:0] brightness
    output logic                  m_tuser,   // [0] light_alert
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    abh_cmd_t  cmd;
    abh_stat_t stat;

    abh_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    abh_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_sample (s_tdata[SAMPLE_BITS-1:0]),
        .in_boost  (s_tuser),
        .cmd       (cmd),
        .stat      (stat),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

endmodule

/* src/abh_ctrl.sv */
// Sequencer for the auto brightness block: input request, divide and map
// steps, result commit. Depends on abh_pkg.
module abh_ctrl
    import abh_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      s_tvalid,
    output logic      s_tready,
    input  abh_stat_t stat,
    output abh_cmd_t  cmd
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_DIV  = 2'd1;
    localparam logic [1:0] S_MAP  = 2'd2;
    localparam logic [1:0] S_FIN  = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    assign s_tready     = (state_reg == S_IDLE);
    assign cmd.load_in  = s_tready && s_tvalid;
    assign cmd.calc_div = (state_reg == S_DIV) && stat.update;
    assign cmd.calc_map = (state_reg == S_MAP);
    assign cmd.commit   = (state_reg == S_FIN) && stat.out_free;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                    state_next = S_DIV;
            end
            S_DIV:
            begin
                // drop requests inside the deadband with no boost change
                state_next = stat.update ? S_MAP : S_IDLE;
            end
            S_MAP:
                state_next = S_FIN;
            S_FIN:
            begin
                if (stat.out_free)
                    state_next = S_IDLE;
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

/* src/abh_datapath.sv */
// Datapath of the auto brightness block: configuration registers, deadband
// compare, gain, divide by 100, mode mapping, clamp and output register.
// Depends on abh_pkg.
module abh_datapath
    import abh_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic [SAMPLE_BITS-1:0] in_sample,
    input  logic                  in_boost,
    input  abh_cmd_t              cmd,
    output abh_stat_t             stat,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_TDATA_W-1:0]  m_tdata,
    output logic                  m_tuser
);

    logic [GAIN_W-1:0]  gain_reg;
    logic [MODE_W-1:0]  mode_reg;
    logic [LEVEL_W-1:0] level_reg;
    logic [LEVEL_W-1:0] boost_add_reg;
    logic               alert_en_reg;

    logic [LAST_W-1:0]  last_sample_reg;
    logic               last_boost_reg;

    logic [SAMPLE_BITS-1:0] cur_reg;
    logic                   boost_reg;
    logic                   update_reg;
    logic                   alert_reg;
    logic [PROD_W-1:0]      prod_reg;
    logic [SCALED_W-1:0]    scaled_reg;
    logic [LPROD_W-1:0]     lprod_reg;

    logic                 out_valid_reg;
    logic [M_TDATA_W-1:0] out_bright_reg;
    logic                 out_alert_reg;

    logic [LAST_W-1:0]      cur_ext;
    logic [LAST_W-1:0]      min_full;
    logic [SAMPLE_BITS-1:0] min_val;
    logic [LAST_W-1:0]      diff;
    logic [LAST_W-1:0]      band;
    logic [LAST_W-1:0]      alert_th;
    logic [PROD_W+RECIP_W-1:0] quot_full;
    logic [LEVEL_W-1:0]     add_val;
    logic [SUM_W-1:0]       sum;
    logic [M_TDATA_W-1:0]   bright;

    // deadband and alert thresholds against the stored sample
    always_comb
    begin
        cur_ext  = LAST_W'(in_sample);
        min_full = (cur_ext < last_sample_reg) ? cur_ext : last_sample_reg;
        min_val  = min_full[SAMPLE_BITS-1:0];
        diff     = (cur_ext > last_sample_reg) ? cur_ext - last_sample_reg
                                               : last_sample_reg - cur_ext;
        band     = (min_val != '0) ? LAST_W'(min_val >> 4) + LAST_W'(1) : '0;
        alert_th = (min_val != '0) ? LAST_W'(min_val >> 3) + LAST_W'(2) : LAST_W'(2);
    end

    assign quot_full = prod_reg * RECIP_100;

    always_comb
    begin
        add_val = boost_reg ? boost_add_reg : '0;
        case (mode_reg)
            MODE_AUTO:
                sum = SUM_W'(scaled_reg >> (SAMPLE_BITS - 8)) + SUM_W'(1) + SUM_W'(add_val);
            MODE_SCALED:
                sum = SUM_W'(lprod_reg >> SAMPLE_BITS) + SUM_W'(1) + SUM_W'(add_val);
            default:
                sum = SUM_W'(level_reg) + SUM_W'(add_val);
        endcase
        if (sum > BRIGHT_MAX)
            bright = 8'd255;
        else if (sum == '0)
            bright = 8'd1;
        else
            bright = sum[M_TDATA_W-1:0];
    end

    assign stat.update   = update_reg;
    assign stat.out_free = !out_valid_reg || m_tready;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_bright_reg;
    assign m_tuser  = out_alert_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_reg      <= GAIN_RST;
            mode_reg      <= MODE_RST;
            level_reg     <= LEVEL_RST;
            boost_add_reg <= BOOST_RST;
            alert_en_reg  <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_GAIN:     gain_reg      <= cfg_data[GAIN_W-1:0];
                CFG_MODE:     mode_reg      <= cfg_data[MODE_W-1:0];
                CFG_LEVEL:    level_reg     <= cfg_data[LEVEL_W-1:0];
                CFG_BOOST:    boost_add_reg <= cfg_data[LEVEL_W-1:0];
                CFG_ALERT_EN: alert_en_reg  <= cfg_data[0];
                default:      ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_sample_reg <= LAST_SAMPLE_RST;
            last_boost_reg  <= 1'b1;
            update_reg      <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cmd.load_in)
                update_reg <= (diff > band) || (in_boost != last_boost_reg);
            if (cmd.commit)
            begin
                last_sample_reg <= LAST_W'(cur_reg);
                last_boost_reg  <= boost_reg;
                out_valid_reg   <= 1'b1;
            end
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            cur_reg   <= in_sample;
            boost_reg <= in_boost;
            alert_reg <= alert_en_reg && (diff > alert_th);
            prod_reg  <= in_sample * gain_reg;
        end
        if (cmd.calc_div)
            scaled_reg <= quot_full[RECIP_SHIFT +: SCALED_W];
        if (cmd.calc_map)
            lprod_reg <= scaled_reg * level_reg;
        if (cmd.commit)
        begin
            out_bright_reg <= bright;
            out_alert_reg  <= alert_reg;
        end
    end

endmodule

/* src/abh_checker.sv */
// Port-level checker for auto_brightness_hysteresis_top, attached by bind.
// Depends on abh_pkg and auto_brightness_hysteresis_top_macros.svh.
`include "auto_brightness_hysteresis_top_macros.svh"

module abh_checker
    import abh_pkg::*;
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  s_tvalid,
    input logic                  s_tready,
    input logic [S_TDATA_W-1:0]  s_tdata,
    input logic                  s_tuser,
    input logic                  m_tvalid,
    input logic                  m_tready,
    input logic [M_TDATA_W-1:0]  m_tdata,
    input logic                  m_tuser,
    input logic                  cfg_we,
    input logic [CFG_IDX_W-1:0]  cfg_index,
    input logic [CFG_DATA_W-1:0] cfg_data
);

    `ABH_ASSERT(a_out_hold, clk, rst_n, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser), "stalled result changed")
    `ABH_ASSERT(a_bright_nonzero, clk, rst_n, m_tvalid |-> m_tdata != '0, "brightness of zero")
    `ABH_ASSERT(a_busy_after_accept, clk, rst_n, s_tvalid && s_tready |=> !s_tready, "request taken while busy")
    `ABH_ASSERT_ALWAYS(a_reset_quiet, clk, !rst_n |-> !m_tvalid, "result valid in reset")

endmodule

bind auto_brightness_hysteresis_top abh_checker u_abh_checker (.*);

/* bench/tb_top.sv */
`timescale 1ns / 100ps
// Self-checking bench for auto_brightness_hysteresis_top: sensor samples in, brightness out.
// Depends on abh_pkg and the RTL under src; a scoreboard class predicts every update.
module tb_top
    import abh_pkg::*;
;

    localparam logic [MODE_W-1:0] MODE_MANUAL = 2'd2;
    localparam logic [MODE_W-1:0] MODE_SPARE  = 2'd3;
    localparam int SAMPLE_MAX    = (1 << SAMPLE_BITS) - 1;
    localparam int SETTLE        = 8;
    localparam int DRAIN_LIMIT   = 5000;
    localparam int LONG_HOLD     = 400;
    localparam int PHASE_SAMPLES = 165;

    typedef struct packed {
        logic [7:0] brightness;
        logic       alert;
    } led_update_t;

    class brightness_scoreboard;
        logic [GAIN_W-1:0]  gain;
        logic [MODE_W-1:0]  mode;
        logic [LEVEL_W-1:0] level;
        logic [7:0]         boost_add;
        logic               alert_en;
        logic [LAST_W-1:0]  last_sample;
        logic               last_boost;
        led_update_t        pending_levels[$];
        int errors, n_samples, n_updates, n_alerts, n_settings;

        function new();
            gain        = GAIN_RST;
            mode        = MODE_RST;
            level       = LEVEL_RST;
            boost_add   = BOOST_RST;
            alert_en    = 1'b0;
            last_sample = LAST_SAMPLE_RST;
            last_boost  = 1'b1;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_GAIN:     gain      = data[GAIN_W-1:0];
                CFG_MODE:     mode      = data[MODE_W-1:0];
                CFG_LEVEL:    level     = data[LEVEL_W-1:0];
                CFG_BOOST:    boost_add = data[7:0];
                CFG_ALERT_EN: alert_en  = data[0];
                default:      ;
            endcase
        endfunction

        // Work out the brightness update, if any, caused by one accepted sample.
        function void note_sample(logic [SAMPLE_BITS-1:0] sample, logic boost);
            int unsigned cur, old, lo, diff, band, alert_th, scaled, add, bright;
            led_update_t upd;
            n_samples++;
            cur      = 32'(sample);
            old      = 32'(last_sample);
            lo       = (cur < old) ? cur : old;
            diff     = (cur > old) ? cur - old : old - cur;
            band     = (lo > 0) ? (lo >> 4) + 1 : 0;
            alert_th = (lo > 0) ? (lo >> 3) + 2 : 2;
            if (diff <= band && boost == last_boost)
                return;
            scaled = (gain != GAIN_RST) ? (cur * 32'(gain)) / 100 : cur;
            add    = boost ? 32'(boost_add) : 0;
            if (mode == MODE_AUTO)
                bright = (scaled >> (SAMPLE_BITS - 8)) + 1 + add;
            else if (mode == MODE_SCALED)
                bright = ((scaled * 32'(level)) >> SAMPLE_BITS) + 1 + add;
            else
                bright = 32'(level) + add;
            if (bright < 1)
                bright = 1;
            if (bright > 255)
                bright = 255;
            upd.brightness = 8'(bright);
            upd.alert      = alert_en && (diff > alert_th);
            pending_levels.push_back(upd);
            n_updates++;
            if (upd.alert)
                n_alerts++;
            last_sample = LAST_W'(cur);
            last_boost  = boost;
        endfunction

        function void check_level(logic [7:0] brightness, logic alert);
            led_update_t want;
            if (pending_levels.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected update: expected none, actual brightness %0d alert %0d",
                         $time, brightness, alert);
                return;
            end
            want = pending_levels.pop_front();
            if (want.brightness !== brightness)
            begin
                errors++;
                $display("%0t: brightness mismatch: expected %0d, actual %0d",
                         $time, want.brightness, brightness);
            end
            if (want.alert !== alert)
            begin
                errors++;
                $display("%0t: light_alert mismatch: expected %0d, actual %0d",
                         $time, want.alert, alert);
            end
        endfunction
    endclass

    logic                  clk;
    logic                  rst_n;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata;
    logic                  s_tuser;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic                  m_tuser;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    brightness_scoreboard sb = new();
    bit sender_gaps = 1'b1;
    bit sink_stalls = 1'b1;
    bit long_hold   = 1'b0;

    auto_brightness_hysteresis_top dut (.*);

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("status: fail");
        $finish;
    end

    // Result side: random stall bursts, plus one long hold-off on request.
    initial
    begin : led_sink
        int hold_left;
        hold_left = 0;
        m_tready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && m_tvalid && m_tready)
                sb.check_level(m_tdata, m_tuser);
            if (long_hold)
            begin
                hold_left = LONG_HOLD;
                long_hold = 1'b0;
            end
            else if (hold_left == 0 && sink_stalls && $urandom_range(0, 7) == 0)
            begin
                hold_left = int'($urandom_range(1, 18));
            end
            if (hold_left > 0)
            begin
                m_tready <= 1'b0;
                hold_left--;
            end
            else
            begin
                m_tready <= 1'b1;
            end
        end
    end

    // Leaves s_tvalid high after the accept; the caller drops it at phase end.
    task automatic send_sample(input logic [SAMPLE_BITS-1:0] sample, input logic boost);
        int gap;
        gap = (sender_gaps && $urandom_range(0, 4) == 0) ? int'($urandom_range(1, 18)) : 0;
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= S_TDATA_W'(sample);
        s_tuser  <= boost;
        do @(posedge clk); while (!s_tready);
        sb.note_sample(sample, boost);
    endtask

    // Mostly big jumps and steps near the deadband edge, some jitter inside it.
    task automatic send_random_sample();
        int pick, base, reach, val;
        logic boost;
        pick  = int'($urandom_range(0, 9));
        base  = (sb.last_sample > SAMPLE_MAX) ? int'($urandom_range(0, SAMPLE_MAX))
                                              : int'(sb.last_sample);
        boost = ($urandom_range(0, 4) == 0) ? ~sb.last_boost : sb.last_boost;
        if (pick < 5)
        begin
            val   = int'($urandom_range(0, SAMPLE_MAX));
            boost = 1'($urandom_range(0, 1));
        end
        else
        begin
            reach = (pick < 8) ? (base >> 4) + 3 : (base >> 5);
            val   = base + (($urandom_range(0, 1) == 0) ? 1 : -1) * int'($urandom_range(0, reach));
            if (val < 0)
                val = 0;
            if (val > SAMPLE_MAX)
                val = SAMPLE_MAX;
        end
        send_sample(SAMPLE_BITS'(val), boost);
    endtask

    // Wait for every update, then let dropped requests clear the pipeline.
    task automatic drain();
        int waited;
        waited = 0;
        s_tvalid <= 1'b0;
        while (sb.pending_levels.size() != 0 && waited < DRAIN_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        if (sb.pending_levels.size() != 0)
        begin
            $display("%0t: missing updates: expected %0d more, actual 0",
                     $time, sb.pending_levels.size());
            sb.errors += sb.pending_levels.size();
            sb.pending_levels.delete();
        end
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic apply_settings(input logic [GAIN_W-1:0] gain, input logic [MODE_W-1:0] mode,
                                  input logic [LEVEL_W-1:0] lvl, input logic [7:0] add,
                                  input logic alert_en);
        logic [CFG_IDX_W-1:0]  idx [5];
        logic [CFG_DATA_W-1:0] val [5];
        idx = '{CFG_GAIN, CFG_MODE, CFG_LEVEL, CFG_BOOST, CFG_ALERT_EN};
        val = '{CFG_DATA_W'(gain), CFG_DATA_W'(mode), CFG_DATA_W'(lvl),
                CFG_DATA_W'(add), CFG_DATA_W'(alert_en)};
        for (int i = 0; i < 5; i++)
        begin
            cfg_we    <= 1'b1;
            cfg_index <= idx[i];
            cfg_data  <= val[i];
            @(posedge clk);
            sb.write_reg(idx[i], val[i]);
        end
        cfg_we <= 1'b0;
        sb.n_settings++;
    endtask

    task automatic apply_random_settings();
        logic [GAIN_W-1:0]  gain;
        logic [LEVEL_W-1:0] lvl;
        logic [7:0]         add;
        case ($urandom_range(0, 5))
            0:       gain = 9'd10;
            1:       gain = GAIN_RST;
            2:       gain = 9'd500;
            3:       gain = 9'd511;
            default: gain = GAIN_W'($urandom_range(0, 511));
        endcase
        lvl = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 1) * 255) : 8'($urandom);
        add = ($urandom_range(0, 2) == 0) ? 8'd0 : 8'($urandom_range(0, 255));
        apply_settings(gain, MODE_W'($urandom_range(0, 3)), lvl, add, 1'($urandom_range(0, 1)));
    endtask

    initial
    begin : stimulus
        int goal;
        rst_n     <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tuser   <= 1'b0;
        cfg_we    <= 1'b0;
        cfg_index <= '0;
        cfg_data  <= '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings: first sample forced through, zero floor, deadband edge.
        send_sample(10'd0, 1'b1);
        send_sample(10'd0, 1'b1);
        send_sample(10'd1, 1'b1);
        send_sample(10'd1023, 1'b1);
        send_sample(10'd963, 1'b1);
        send_sample(10'd962, 1'b1);
        send_sample(10'd961, 1'b1);
        send_sample(10'd961, 1'b0);
        send_sample(10'd512, 1'b0);
        drain();

        // Gain 500, scaled mode, saturating add; alert just under and over threshold.
        apply_settings(9'd500, MODE_SCALED, 8'd255, 8'd255, 1'b1);
        send_sample(10'd0, 1'b0);
        send_sample(10'd2, 1'b0);
        send_sample(10'd5, 1'b1);
        send_sample(10'd1023, 1'b1);
        send_sample(10'd700, 1'b0);
        drain();

        // Manual at level zero, no add: floor of one.
        apply_settings(9'd0, MODE_MANUAL, 8'd0, 8'd0, 1'b1);
        send_sample(10'd1023, 1'b0);
        send_sample(10'd0, 1'b1);
        drain();

        apply_settings(9'd511, MODE_SPARE, 8'd255, 8'd0, 1'b0);
        send_sample(10'd1023, 1'b1);
        send_sample(10'd100, 1'b0);
        drain();

        apply_settings(9'd10, MODE_AUTO, 8'd1, 8'd255, 1'b0);
        send_sample(10'd1023, 1'b1);
        send_sample(10'd3, 1'b0);
        drain();

        for (int phase = 0; phase < 8; phase++)
        begin
            apply_random_settings();
            if (phase == 3)
                long_hold = 1'b1;
            if (phase == 7)
            begin
                sender_gaps = 1'b0;
                sink_stalls = 1'b0;
            end
            goal = sb.n_samples + PHASE_SAMPLES;
            while (sb.n_samples < goal)
                send_random_sample();
            drain();
        end

        $display("covered %0d samples, %0d brightness updates (%0d with alert set)",
                 sb.n_samples, sb.n_updates, sb.n_alerts);
        $display("under %0d register settings, with one long output hold-off", sb.n_settings);
        if (sb.errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

/* sim.f */
+incdir+src
src/abh_pkg.sv
src/abh_ctrl.sv
src/abh_datapath.sv
src/auto_brightness_hysteresis_top.sv
src/abh_checker.sv
bench/tb_top.sv
